/* src/point_perspective_projector_core_defines.svh */
// Assertion macros for the projector core.
`ifndef POINT_PERSPECTIVE_PROJECTOR_CORE_DEFINES_SVH
`define POINT_PERSPECTIVE_PROJECTOR_CORE_DEFINES_SVH

// Check that a condition implies a consequent in the same cycle.
`define PPC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequent after the delay dly.
`define PPC_ASSERT_LATER(label, cond, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* src/ppc_pkg.sv */
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int NUM_W  = 52;  // rotated coordinates and depth, Q.30
  localparam int MAG_W  = 51;  // magnitude and positive depth
  localparam int GAIN_W = 31;
  localparam int PROD_W = 82;  // magnitude times gain
  localparam int QUOT_W = 41;  // quotient bits 40..0
  localparam int DIV_LAT = 45; // divider pipeline depth

  typedef enum logic [2:0] {
    REG_COS_V  = 3'd0,
    REG_SIN_V  = 3'd1,
    REG_COS_H  = 3'd2,
    REG_SIN_H  = 3'd3,
    REG_VIEW_X = 3'd4,
    REG_VIEW_Z = 3'd5,
    REG_DEPTH  = 3'd6,
    REG_GAIN   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               depth_invalid;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic signed [15:0]     cos_vertical;
    logic signed [15:0]     sin_vertical;
    logic signed [15:0]     cos_horizontal;
    logic signed [15:0]     sin_horizontal;
    logic signed [31:0]     view_x;
    logic signed [31:0]     view_z;
    logic signed [31:0]     depth_offset;
    logic [GAIN_W-1:0]      proj_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] rx;
    logic signed [NUM_W-1:0] ry;
    logic signed [NUM_W-1:0] depth;
    logic                    last;
  } rot_t;

endpackage

/* src/ppc_rotate.sv */
`timescale 1ns / 1ps
module ppc_rotate
  import ppc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  point_t in_point,
  output logic   out_valid,
  output rot_t   out_rot
);

  // Stage 1: products of the coordinates with the angle terms.
  logic               v1;
  logic signed [47:0] xch1, ysh1, xsh1, ych1, zcv1, zsv1;
  logic               last1;
  // Stage 2: first rotation.
  logic               v2;
  logic signed [34:0] a16_2;
  logic signed [NUM_W-1:0] rx2;
  logic signed [47:0] zcv2, zsv2;
  logic               last2;
  // Stage 3: second rotation products.
  logic               v3;
  logic signed [50:0] a16sv3, a16cv3;
  logic signed [NUM_W-1:0] rx3;
  logic signed [47:0] zcv3, zsv3;
  logic               last3;

  logic signed [48:0] a_sum;
  assign a_sum = 49'(xsh1) + 49'(ych1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    xch1  <= 48'(in_point.point_x) * 48'(cfg.cos_horizontal);
    ysh1  <= 48'(in_point.point_y) * 48'(cfg.sin_horizontal);
    xsh1  <= 48'(in_point.point_x) * 48'(cfg.sin_horizontal);
    ych1  <= 48'(in_point.point_y) * 48'(cfg.cos_horizontal);
    zcv1  <= 48'(in_point.point_z) * 48'(cfg.cos_vertical);
    zsv1  <= 48'(in_point.point_z) * 48'(cfg.sin_vertical);
    last1 <= in_point.last_point;

    // arithmetic shift is the floor divide by 2^14
    a16_2 <= 35'(a_sum >>> 14);
    rx2   <= NUM_W'(xch1) - NUM_W'(ysh1) - (NUM_W'(cfg.view_x) <<< 14);
    zcv2  <= zcv1;
    zsv2  <= zsv1;
    last2 <= last1;

    a16sv3 <= 51'(a16_2) * 51'(cfg.sin_vertical);
    a16cv3 <= 51'(a16_2) * 51'(cfg.cos_vertical);
    rx3    <= rx2;
    zcv3   <= zcv2;
    zsv3   <= zsv2;
    last3  <= last2;

    out_rot.rx    <= rx3;
    out_rot.ry    <= NUM_W'(a16sv3) + NUM_W'(zcv3) - (NUM_W'(cfg.view_z) <<< 14);
    out_rot.depth <= NUM_W'(a16cv3) - NUM_W'(zsv3) + (NUM_W'(cfg.depth_offset) <<< 14);
    out_rot.last  <= last3;
  end

endmodule

/* src/ppc_div.sv */
`timescale 1ns / 1ps
module ppc_div
  import ppc_pkg::*;
(
  input  logic                    clk,
  input  logic signed [NUM_W-1:0] num,
  input  logic [MAG_W-1:0]        den,
  input  logic [GAIN_W-1:0]       gain,
  output logic [QUOT_W-1:0]       quot,
  output logic                    clamp
);

  logic [MAG_W-1:0]  mag0, den0;
  logic [62:0]       plo;
  logic [49:0]       phi;
  logic [MAG_W-1:0]  dena, denb;
  logic [PROD_W-1:0] prod;

  logic [MAG_W-1:0]  rem   [0:QUOT_W];
  logic [QUOT_W-1:0] lowb  [0:QUOT_W];
  logic [QUOT_W-1:0] qacc  [0:QUOT_W];
  logic [MAG_W-1:0]  dens  [0:QUOT_W];
  logic              clmp  [0:QUOT_W];

  always_ff @(posedge clk) begin
    mag0 <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den0 <= den;

    // split the wide product into two partial products
    plo  <= 63'(mag0[31:0]) * 63'(gain);
    phi  <= 50'(mag0[MAG_W-1:32]) * 50'(gain);
    dena <= den0;

    prod <= PROD_W'(plo) + (PROD_W'(phi) << 32);
    denb <= dena;

    // quotient of 2^41 or more saturates
    clmp[0] <= MAG_W'(prod[PROD_W-1:QUOT_W]) >= denb;
    rem[0]  <= MAG_W'(prod[PROD_W-1:QUOT_W]);
    lowb[0] <= prod[QUOT_W-1:0];
    qacc[0] <= '0;
    dens[0] <= denb;
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic           fit;
    assign trial = {rem[k], lowb[k][QUOT_W-1]};
    assign fit   = trial >= {1'b0, dens[k]};
    always_ff @(posedge clk) begin
      rem[k+1]  <= fit ? MAG_W'(trial - {1'b0, dens[k]}) : MAG_W'(trial);
      lowb[k+1] <= lowb[k] << 1;
      qacc[k+1] <= {qacc[k][QUOT_W-2:0], fit};
      dens[k+1] <= dens[k];
      clmp[k+1] <= clmp[k];
    end
  end

  assign quot  = qacc[QUOT_W];
  assign clamp = clmp[QUOT_W];

endmodule

/* src/point_perspective_projector_core.sv */
// Channel   Handshake              Beat
// -------   --------------------   ------------------------------------
// point     start & !busy          point_t: point_x/y/z, last_point
// result    done (one cycle)       result_t: screen_x/y, depth_invalid, last_out
// config    cfg_we                 cfg_index selects register, cfg_data value
//
// One beat enters every cycle; busy never rises.
// Each result leaves once its point has passed 4 rotation stages,
// a 45-stage divider (one quotient bit per stage over 41 bits) and 1 output stage.
// Synchronous reset clears valid bits and restores register defaults.
// The receiver takes every result as it appears; nothing ever stalls.
`timescale 1ns / 1ps
`include "point_perspective_projector_core_defines.svh"
module point_perspective_projector_core
  import ppc_pkg::*;
#(
  parameter int WINDOW_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  point_t      point,
  output logic        busy,
  output logic        done,
  output result_t     result
);

  localparam logic signed [27:0] CENTER = 28'(WINDOW_SIZE / 2);
  localparam logic [QUOT_W-1:0]  QCAP   = QUOT_W'(1) << (QUOT_W - 1);
  localparam int TOTAL_LAT = 4 + DIV_LAT + 1;

  typedef struct packed {
    logic x_neg;
    logic x_zero;
    logic y_neg;
    logic y_zero;
    logic invalid;
    logic last;
  } side_t;

  cfg_t  cfg;
  logic  rot_valid;
  rot_t  rot;
  side_t side_in;
  side_t side   [0:DIV_LAT-1];
  logic  vline  [0:DIV_LAT-1];
  logic [QUOT_W-1:0] qx, qy;
  logic  cx, cy;

  // Never hold off a point.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_vertical   <= 16'sd16384;
      cfg.sin_vertical   <= '0;
      cfg.cos_horizontal <= 16'sd16384;
      cfg.sin_horizontal <= '0;
      cfg.view_x         <= '0;
      cfg.view_z         <= '0;
      cfg.depth_offset   <= 32'sd65536000;
      cfg.proj_gain      <= 31'd65536000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS_V:  cfg.cos_vertical   <= cfg_data[15:0];
        REG_SIN_V:  cfg.sin_vertical   <= cfg_data[15:0];
        REG_COS_H:  cfg.cos_horizontal <= cfg_data[15:0];
        REG_SIN_H:  cfg.sin_horizontal <= cfg_data[15:0];
        REG_VIEW_X: cfg.view_x         <= cfg_data;
        REG_VIEW_Z: cfg.view_z         <= cfg_data;
        REG_DEPTH:  cfg.depth_offset   <= cfg_data;
        REG_GAIN:   cfg.proj_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Rotate and shift by the viewpoint.
  ppc_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (start & ~busy),
    .in_point  (point),
    .out_valid (rot_valid),
    .out_rot   (rot)
  );

  // Divide gain-scaled magnitudes by depth, one divider per axis.
  ppc_div u_div_x (
    .clk   (clk),
    .num   (rot.rx),
    .den   (rot.depth[MAG_W-1:0]),
    .gain  (cfg.proj_gain),
    .quot  (qx),
    .clamp (cx)
  );

  ppc_div u_div_y (
    .clk   (clk),
    .num   (rot.ry),
    .den   (rot.depth[MAG_W-1:0]),
    .gain  (cfg.proj_gain),
    .quot  (qy),
    .clamp (cy)
  );

  // Carry signs, depth flag and end marker alongside the dividers.
  assign side_in.x_neg   = rot.rx[NUM_W-1];
  assign side_in.x_zero  = (rot.rx == '0);
  assign side_in.y_neg   = rot.ry[NUM_W-1];
  assign side_in.y_zero  = (rot.ry == '0);
  assign side_in.invalid = rot.depth[NUM_W-1] | (rot.depth == '0);
  assign side_in.last    = rot.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vline[i] <= 1'b0;
    end else begin
      vline[0] <= rot_valid;
      for (int i = 1; i < DIV_LAT; i++) vline[i] <= vline[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int i = 1; i < DIV_LAT; i++) side[i] <= side[i-1];
  end

  // Clamp and round, apply sign, offset from the window center, pin for a bad depth and saturate.
  function automatic logic signed [15:0] place(
    input logic [QUOT_W-1:0] q,
    input logic              clmp,
    input logic              neg,
    input logic              zero,
    input logic              invalid,
    input logic              down
  );
    logic [QUOT_W-1:0]  qc;
    logic [QUOT_W:0]    rnd;
    logic [25:0]        p;
    logic signed [27:0] v;
    logic               up_dir, dn_dir;
    up_dir = down ? neg : (~neg & ~zero);
    dn_dir = down ? (~neg & ~zero) : neg;
    qc  = (clmp || q > QCAP) ? QCAP : q;
    rnd = (QUOT_W+1)'(qc) + (QUOT_W+1)'(32768);
    p   = rnd[QUOT_W:16];
    if (up_dir)      v = CENTER + $signed({2'b00, p});
    else if (dn_dir) v = CENTER - $signed({2'b00, p});
    else             v = CENTER;
    if (invalid) begin
      if (up_dir)      v = 28'sd32767;
      else if (dn_dir) v = -28'sd32768;
      else             v = CENTER;
    end
    if (v > 28'sd32767)       place = 16'sh7fff;
    else if (v < -28'sd32768) place = 16'sh8000;
    else                      place = v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vline[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    result.screen_x <= place(qx, cx, side[DIV_LAT-1].x_neg, side[DIV_LAT-1].x_zero,
                             side[DIV_LAT-1].invalid, 1'b0);
    result.screen_y <= place(qy, cy, side[DIV_LAT-1].y_neg, side[DIV_LAT-1].y_zero,
                             side[DIV_LAT-1].invalid, 1'b1);
    result.depth_invalid <= side[DIV_LAT-1].invalid;
    result.last_out      <= side[DIV_LAT-1].last;
  end

  // Every taken point yields its result after the fixed latency.
  `PPC_ASSERT_LATER(a_latency, start && !busy, TOTAL_LAT, done, "result missing after point")
  // A bad depth pins x to an edge or the center.
  `PPC_ASSERT_NOW(a_inv_x, done && result.depth_invalid, result.screen_x == 16'sh7fff || result.screen_x == 16'sh8000 || result.screen_x == 16'(WINDOW_SIZE / 2), "bad depth x not pinned")
  // A bad depth pins y to an edge or the center.
  `PPC_ASSERT_NOW(a_inv_y, done && result.depth_invalid, result.screen_y == 16'sh7fff || result.screen_y == 16'sh8000 || result.screen_y == 16'(WINDOW_SIZE / 2), "bad depth y not pinned")

endmodule

/* sim/ppc_checker.sv */
`timescale 1ns / 1ps
module ppc_checker
  import ppc_pkg::*;
#(
  parameter int WINDOW_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  point_t      point,
  input  logic        done,
  input  result_t     result,
  output int          fail_count,
  output int          pending
);

  localparam longint CENTER = WINDOW_SIZE / 2;

  cfg_t    regs;
  result_t screen_q[$];

  assign pending = screen_q.size();

  // Scale one rotated coordinate by gain / depth and place it on screen.
  function automatic logic signed [15:0] place(longint num, bit down, longint depth,
                                               logic [GAIN_W-1:0] gain);
    longint sgn, p, v;
    logic [127:0] prod, quot;
    sgn = (num > 0) ? 1 : ((num < 0) ? -1 : 0);
    if (down) sgn = -sgn;
    if (depth <= 0) begin
      if (sgn > 0) return 16'sh7fff;
      if (sgn < 0) return 16'sh8000;
      v = CENTER;
    end else begin
      prod = 128'((num < 0) ? -num : num) * 128'(gain);
      quot = prod / 128'(depth);
      if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
      p = longint'((quot + 128'd32768) >> 16);
      v = CENTER + sgn * p;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic result_t project_point(point_t pt, cfg_t c);
    longint x, y, z, a16, rx, ry, depth;
    result_t r;
    x = pt.point_x;
    y = pt.point_y;
    z = pt.point_z;
    a16 = (x * longint'(c.sin_horizontal) + y * longint'(c.cos_horizontal)) >>> 14;
    rx = x * longint'(c.cos_horizontal) - y * longint'(c.sin_horizontal)
         - longint'(c.view_x) * 16384;
    ry = a16 * longint'(c.sin_vertical) + z * longint'(c.cos_vertical)
         - longint'(c.view_z) * 16384;
    depth = a16 * longint'(c.cos_vertical) - z * longint'(c.sin_vertical)
            + longint'(c.depth_offset) * 16384;
    r.screen_x = place(rx, 1'b0, depth, c.proj_gain);
    r.screen_y = place(ry, 1'b1, depth, c.proj_gain);
    r.depth_invalid = (depth <= 0);
    r.last_out = pt.last_point;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      regs.cos_vertical <= 16'sd16384;
      regs.sin_vertical <= '0;
      regs.cos_horizontal <= 16'sd16384;
      regs.sin_horizontal <= '0;
      regs.view_x <= '0;
      regs.view_z <= '0;
      regs.depth_offset <= 32'sd65536000;
      regs.proj_gain <= 31'd65536000;
      screen_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_COS_V:  regs.cos_vertical <= cfg_data[15:0];
          REG_SIN_V:  regs.sin_vertical <= cfg_data[15:0];
          REG_COS_H:  regs.cos_horizontal <= cfg_data[15:0];
          REG_SIN_H:  regs.sin_horizontal <= cfg_data[15:0];
          REG_VIEW_X: regs.view_x <= cfg_data;
          REG_VIEW_Z: regs.view_z <= cfg_data;
          REG_DEPTH:  regs.depth_offset <= cfg_data;
          REG_GAIN:   regs.proj_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (screen_q.size() == 0) begin
          $error("result beat with nothing expected: %h", result);
          errs++;
        end else begin
          want = screen_q.pop_front();
          if (result.screen_x !== want.screen_x) begin
            $error("screen_x expected %0d actual %0d", want.screen_x, result.screen_x);
            errs++;
          end
          if (result.screen_y !== want.screen_y) begin
            $error("screen_y expected %0d actual %0d", want.screen_y, result.screen_y);
            errs++;
          end
          if (result.depth_invalid !== want.depth_invalid) begin
            $error("depth_invalid expected %0b actual %0b",
                   want.depth_invalid, result.depth_invalid);
            errs++;
          end
          if (result.last_out !== want.last_out) begin
            $error("last_out expected %0b actual %0b", want.last_out, result.last_out);
            errs++;
          end
        end
      end
      if (start && !busy) screen_q.push_back(project_point(point, regs));
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import ppc_pkg::*;

  localparam int DRAIN_CYCLES = 60;  // covers the full pipeline

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  point_t      point = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int          fail_count;
  int          pending;
  int          burst_left = 0;

  always #5 clk = ~clk;

  point_perspective_projector_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .point(point), .busy(busy), .done(done), .result(result)
  );

  ppc_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .point(point), .done(done), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  // Drop start, then hold until the pipeline has emptied and settled.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one beat; between bursts leave a random gap on the point channel.
  task automatic send_point(point_t p);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
    end
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  function automatic point_t mk(int x, int y, int z, bit last);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.last_point = last;
    return p;
  endfunction

  // Mostly on-screen coordinates, with some full-range and zero components.
  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return int'($urandom);
      1: return 0;
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      3: return int'($urandom_range(0, 131072)) - 65536;
      default: return int'($urandom_range(0, 78643200)) - 39321600;
    endcase
  endfunction

  function automatic logic [31:0] rand_trig();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'(16384);
      2: return 32'(-16384);
      3: return 32'(0);
      default: return 32'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_q16(int span);
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_config();
    write_reg(REG_COS_V, rand_trig());
    write_reg(REG_SIN_V, rand_trig());
    write_reg(REG_COS_H, rand_trig());
    write_reg(REG_SIN_H, rand_trig());
    write_reg(REG_VIEW_X, rand_q16(6553600));
    write_reg(REG_VIEW_Z, rand_q16(6553600));
    case ($urandom_range(0, 5))
      0: write_reg(REG_DEPTH, $urandom);
      1: write_reg(REG_DEPTH, 32'(int'($urandom_range(0, 131072)) - 65536));
      default: write_reg(REG_DEPTH, 32'($urandom_range(6553600, 131072000)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_GAIN, $urandom);  // top bit is dropped
      1: write_reg(REG_GAIN, 32'h7fffffff);
      2: write_reg(REG_GAIN, 32'h0);
      default: write_reg(REG_GAIN, 32'($urandom_range(6553600, 131072000)));
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: center, coordinate extremes, unit pixel steps, end marker.
    send_point(mk(0, 0, 0, 1'b0));
    send_point(mk(32'sh7fffffff, 0, 32'sh7fffffff, 1'b1));
    send_point(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0));
    send_point(mk(32'sh7fffffff, 32'sh7fffffff, 0, 1'b0));
    send_point(mk(32768, 0, -32768, 1'b1));
    send_point(mk(-32768, 65536, 32767, 1'b0));
    send_point(mk(100 << 16, 0, -200 << 16, 1'b0));
    drain();

    // Zero gain: everything lands on the center.
    write_reg(REG_GAIN, 32'h0);
    send_point(mk(12345678, -3, -98765432, 1'b1));
    send_point(mk(32'sh80000000, 5, 32'sh7fffffff, 1'b0));
    drain();

    // Non-positive depth: coordinates pinned by sign alone.
    write_reg(REG_GAIN, 32'h7fffffff);
    write_reg(REG_DEPTH, 32'h80000000);
    send_point(mk(65536, 0, 65536, 1'b0));
    send_point(mk(-65536, 0, -65536, 1'b1));
    send_point(mk(0, 0, 0, 1'b0));
    drain();
    write_reg(REG_DEPTH, 32'h0);
    send_point(mk(0, 0, 0, 1'b0));
    drain();

    // Tiny depth with maximum gain: quotient clamps and coordinates saturate.
    write_reg(REG_DEPTH, 32'h1);
    send_point(mk(32'sh7fffffff, 0, 32'sh80000000, 1'b0));
    send_point(mk(1, 0, -1, 1'b1));
    drain();

    // Rotation and view extremes.
    write_reg(REG_COS_V, 32'(-16384));
    write_reg(REG_SIN_V, 32'(16384));
    write_reg(REG_COS_H, 32'(-16384));
    write_reg(REG_SIN_H, 32'(-16384));
    write_reg(REG_VIEW_X, 32'h7fffffff);
    write_reg(REG_VIEW_Z, 32'h80000000);
    write_reg(REG_DEPTH, 32'h7fffffff);
    write_reg(REG_GAIN, 32'(65536000));
    send_point(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1));
    send_point(mk(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0));
    send_point(mk(0, 0, 0, 1'b1));
    drain();

    // Random phases; each reprograms every register.
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      for (int n = 0; n < 100; n++) begin
        send_point(mk(rand_coord(), rand_coord(), rand_coord(), 1'($urandom)));
        if (ph == 3 && n == 50) drain();  // let the pipeline run dry mid-phase
      end
      drain();
    end

    if (fail_count == 0)
      $display("point_perspective_projector_core verification clean");
    else
      $display("point_perspective_projector_core verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("point_perspective_projector_core verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/ppc_pkg.sv
src/ppc_rotate.sv
src/ppc_div.sv
src/point_perspective_projector_core.sv
sim/ppc_checker.sv
sim/tb.sv
